// ===== rtl/vsrclp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrclp_pkg: shared definitions for the variable-step RC low-pass filter
// Widths, constants, controller states and the command and status records
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package vsrclp_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int TC_W         = 20;
    localparam int MS_W         = 10;
    localparam int S_W          = 22;
    localparam int STAMP_W      = 32;

    localparam logic [TC_W-1:0] TC_RESET = TC_W'(1000);
    localparam int MS_PER_S = 1000;

    // Product RC * |y_prev - x| and divisor RC + dt.
    localparam int PROD_W = TC_W + SAMPLE_WIDTH;
    localparam int DEN_W  = STAMP_W + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int EXT_W  = SAMPLE_WIDTH + 2;
    localparam int CNT_W  = $clog2(PROD_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STAMP,
        S_MULT,
        S_DEN,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic calc_stamp;
        logic mult;
        logic den_init;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ===== rtl/vsrclp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrclp_ctrl: sequencing controller
// Steps one request through timestamp, multiply, divisor setup, the
// bit-serial divide and the final write of the result.
// ----------------------------------------------------------------------------
module vsrclp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_busy,
    input  vsrclp_pkg::t_status i_status,
    output vsrclp_pkg::t_cmd    o_cmd
);
    import vsrclp_pkg::*;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_STAMP;
                end
            end
            S_STAMP: begin
                o_cmd.calc_stamp = 1'b1;
                n_state          = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_DEN;
            end
            S_DEN: begin
                o_cmd.den_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Wait here while the previous result still sits unread.
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/vsrclp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrclp_dp: filter datapath
// Holds the time constant, the filter state, the operand registers, a
// restoring divider that retires one quotient bit a cycle, and the result.
// ----------------------------------------------------------------------------
module vsrclp_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [vsrclp_pkg::TC_W-1:0]           i_cfg_wr_data,
    input  logic signed [vsrclp_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  logic [vsrclp_pkg::MS_W-1:0]           i_time_ms,
    input  logic [vsrclp_pkg::S_W-1:0]            i_time_s,
    input  vsrclp_pkg::t_cmd                      i_cmd,
    output vsrclp_pkg::t_status                   o_status,
    input  logic                                  i_stall,
    output logic                                  o_valid,
    output logic signed [vsrclp_pkg::SAMPLE_WIDTH-1:0] o_filtered
);
    import vsrclp_pkg::*;

    logic [TC_W-1:0]                r_tc;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic [MS_W-1:0]                r_ms;
    logic [S_W-1:0]                 r_s;
    logic [STAMP_W-1:0]             r_stamp;
    logic [STAMP_W-1:0]             r_last_stamp;
    logic signed [SAMPLE_WIDTH-1:0] r_last_out;
    logic                           r_neg;
    logic [SAMPLE_WIDTH-1:0]        r_mag;
    logic [STAMP_W-1:0]             r_dt;
    logic [DEN_W-1:0]               r_den;
    logic [DEN_W-1:0]               r_rem;
    logic [PROD_W-1:0]              r_quo;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_filtered;

    logic [STAMP_W-1:0]             stamp_c;
    logic signed [SAMPLE_WIDTH:0]   diff_c;
    logic [SAMPLE_WIDTH:0]          mag_c;
    logic [PROD_W-1:0]              prod_c;
    logic [REM_W-1:0]               rem_sh;
    logic                           ge;
    logic [REM_W-1:0]               rem_sub;
    logic signed [EXT_W-1:0]        x_ext, q_ext, r1_ext, fl, ce, sum_fl, sum_ce;
    logic signed [SAMPLE_WIDTH-1:0] y_c;

    // Timestamp in milliseconds, wrapping at 32 bits.
    assign stamp_c = STAMP_W'(r_s) * STAMP_W'(MS_PER_S) + STAMP_W'(r_ms);

    assign diff_c = {r_last_out[SAMPLE_WIDTH-1], r_last_out} - {r_x[SAMPLE_WIDTH-1], r_x};
    assign mag_c  = diff_c[SAMPLE_WIDTH] ? (SAMPLE_WIDTH + 1)'(-diff_c) : diff_c;
    assign prod_c = {{SAMPLE_WIDTH{1'b0}}, r_tc} * {{TC_W{1'b0}}, r_mag};

    // One restoring divide step.
    assign rem_sh  = {r_rem, r_quo[PROD_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    // Truncation toward zero of x + RC*(y_prev - x)/den.
    always_comb begin
        x_ext  = EXT_W'(r_x);
        q_ext  = $signed({{(EXT_W-SAMPLE_WIDTH){1'b0}}, r_quo[SAMPLE_WIDTH-1:0]});
        r1_ext = $signed({{(EXT_W-1){1'b0}}, (r_rem != '0)});
        fl     = r_neg ? (-q_ext - r1_ext) : q_ext;
        ce     = r_neg ? -q_ext : (q_ext + r1_ext);
        sum_fl = x_ext + fl;
        sum_ce = x_ext + ce;
        if (r_den == '0) begin
            y_c = r_last_out;
        end else if (sum_fl[EXT_W-1]) begin
            y_c = sum_ce[SAMPLE_WIDTH-1:0];
        end else begin
            y_c = sum_fl[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc         <= TC_RESET;
            r_last_stamp <= '0;
            r_last_out   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tc <= i_cfg_wr_data;
            end
            if (i_cmd.finish) begin
                r_last_stamp <= r_stamp;
                r_last_out   <= y_c;
                r_out_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= i_sample;
            r_ms <= i_time_ms;
            r_s  <= i_time_s;
        end
        if (i_cmd.calc_stamp) begin
            r_stamp <= stamp_c;
            r_neg   <= diff_c[SAMPLE_WIDTH];
            r_mag   <= mag_c[SAMPLE_WIDTH-1:0];
        end
        if (i_cmd.mult) begin
            r_quo <= prod_c;
            r_dt  <= r_stamp - r_last_stamp;
        end
        if (i_cmd.den_init) begin
            r_den <= DEN_W'(r_tc) + DEN_W'(r_dt);
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], ge};
        end
        if (i_cmd.finish) begin
            r_filtered <= y_c;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_stall;
    assign o_valid           = r_out_valid;
    assign o_filtered        = r_filtered;

endmodule

// ===== rtl/variable_step_rc_low_pass.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_step_rc_low_pass: first-order RC low-pass with a variable step
// Each request carries a sample and a timestamp; the block returns
// y = (RC*y_prev + dt*x) / (RC + dt), truncated toward zero.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Contents
//  input     in         i_valid / o_stall  i_sample, i_time_ms, i_time_s
//  output    out        o_valid / i_stall  o_filtered
//  config    in         i_cfg_wr_en        i_cfg_wr_data (time constant, ms)
//
// After acceptance a request passes through the timestamp, the multiply and the
// divisor setup, then the bit-serial restoring divider (one bit of the 36-bit
// product per cycle), and a final step that writes the result and the filter
// state. The next request is accepted only after that final step.
// The synchronous reset sets the time constant to 1000 ms and clears the
// previous timestamp and output to zero.
// A stalled result waits in the output register; the controller holds in
// its final state until that register can take the new result.
// ----------------------------------------------------------------------------
module variable_step_rc_low_pass (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_wr_en,
    input  logic [vsrclp_pkg::TC_W-1:0]                i_cfg_wr_data,
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  logic signed [vsrclp_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  logic [vsrclp_pkg::MS_W-1:0]                i_time_ms,
    input  logic [vsrclp_pkg::S_W-1:0]                 i_time_s,
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output logic signed [vsrclp_pkg::SAMPLE_WIDTH-1:0] o_filtered
);
    import vsrclp_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    busy;

    // The controller sequences one request at a time; it raises o_stall
    // from the cycle after acceptance until the result has been written.
    vsrclp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_busy   (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // The datapath holds every operand, the divider and the output register.
    vsrclp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sample      (i_sample),
        .i_time_ms     (i_time_ms),
        .i_time_s      (i_time_s),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_filtered    (o_filtered)
    );

    assign o_stall = busy;

    // An accepted request makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting a request");

    // The controller issues at most one command per cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.calc_stamp, cmd.mult, cmd.den_init,
                  cmd.div_step, cmd.finish}))
        else $error("more than one datapath command at once");

    // A new result appears only right after the finishing step.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(cmd.finish))
        else $error("output valid rose without a finished request");

    // The finishing step never overwrites an unread, stalled result.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!o_valid || !i_stall))
        else $error("result written over a stalled result");

endmodule
